// ----- hw/rtl/brfwm_pkg.sv -----
// brfwm_pkg: widths, request and level codes, register map and shared types
// for the byte ring fifo with watermarks
// depends on nothing; imported by every other file of the block
package brfwm_pkg;

    localparam int DEPTH_LOG2 = 10;
    localparam int DEPTH      = 1 << DEPTH_LOG2;
    localparam int PTR_W      = DEPTH_LOG2 + 1;
    localparam int CNT_W      = DEPTH_LOG2 + 1;
    localparam int OFS_W      = DEPTH_LOG2;
    localparam int SIZE_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int REQ_W      = 2;
    localparam int LVL_W      = 2;
    localparam int MIN_LOG2   = 3;

    // apb register map
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam int REG_IDX_W = APB_AW - 2;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_LOG2 = '0;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // watermark levels
    localparam logic [LVL_W-1:0] LVL_LOW  = 2'd0;
    localparam logic [LVL_W-1:0] LVL_HALF = 2'd1;
    localparam logic [LVL_W-1:0] LVL_3Q   = 2'd2;
    localparam logic [LVL_W-1:0] LVL_FULL = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = SIZE_W'(DEPTH_LOG2);

    typedef struct packed {
        logic [CNT_W-1:0] fill_count;
        logic [CNT_W-1:0] free_count;
        logic [OFS_W-1:0] wr_offset;
        logic [CNT_W-1:0] wr_span;
        logic [OFS_W-1:0] rd_offset;
        logic [CNT_W-1:0] rd_span;
        logic [LVL_W-1:0] level;
    } status_t;

    typedef struct packed {
        logic    rd_ok;
        logic    accepted;
        logic    watermark_event;
        status_t st;
    } stage_t;

    // clamp the programmed size to the supported range
    function automatic logic [SIZE_W-1:0] cap_log2(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s < SIZE_W'(MIN_LOG2))
            r = SIZE_W'(MIN_LOG2);
        else if (s > SIZE_W'(DEPTH_LOG2))
            r = SIZE_W'(DEPTH_LOG2);
        return r;
    endfunction

endpackage

// ----- hw/rtl/brfwm_if.sv -----
// brfwm_req_if and brfwm_rsp_if: valid/ready channels carrying requests and results
// depends on brfwm_pkg
interface brfwm_req_if;
    import brfwm_pkg::*;

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] wr_byte;

    modport source (output valid, output req_type, output wr_byte, input ready);
    modport sink   (input valid, input req_type, input wr_byte, output ready);
endinterface

interface brfwm_rsp_if;
    import brfwm_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rd_byte;
    logic              accepted;
    logic [CNT_W-1:0]  fill_count;
    logic [CNT_W-1:0]  free_count;
    logic [OFS_W-1:0]  wr_offset;
    logic [CNT_W-1:0]  wr_span;
    logic [OFS_W-1:0]  rd_offset;
    logic [CNT_W-1:0]  rd_span;
    logic [LVL_W-1:0]  level;
    logic              watermark_event;

    modport source (
        output valid, output rd_byte, output accepted, output fill_count,
        output free_count, output wr_offset, output wr_span, output rd_offset,
        output rd_span, output level, output watermark_event, input ready
    );
    modport sink (
        input valid, input rd_byte, input accepted, input fill_count,
        input free_count, input wr_offset, input wr_span, input rd_offset,
        input rd_span, input level, input watermark_event, output ready
    );
endinterface

// ----- hw/rtl/brfwm_status.sv -----
// brfwm_status: fill, free, span, offset and watermark level from the pointers
// depends on brfwm_pkg
module brfwm_status (
    input  logic [brfwm_pkg::PTR_W-1:0] wp,
    input  logic [brfwm_pkg::PTR_W-1:0] rp,
    input  logic [brfwm_pkg::CNT_W-1:0] size,
    input  logic [brfwm_pkg::OFS_W-1:0] mask,
    output brfwm_pkg::status_t          st
);
    import brfwm_pkg::*;

    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] left;
    logic [OFS_W-1:0] wo;
    logic [OFS_W-1:0] ro;
    logic [CNT_W-1:0] wo_x;
    logic [CNT_W-1:0] ro_x;

    assign fill = CNT_W'(wp - rp);
    assign left = size - fill;
    assign wo   = wp[OFS_W-1:0] & mask;
    assign ro   = rp[OFS_W-1:0] & mask;
    assign wo_x = {1'b0, wo};
    assign ro_x = {1'b0, ro};

    always_comb
    begin
        st            = '0;
        st.fill_count = fill;
        st.free_count = left;
        st.wr_offset  = wo;
        st.rd_offset  = ro;

        if (wo > ro)
        begin
            st.wr_span = size - wo_x;
            st.rd_span = wo_x - ro_x;
        end
        else if (wo < ro)
        begin
            st.wr_span = ro_x - wo_x;
            st.rd_span = size - ro_x;
        end
        else if (fill == '0)
        begin
            // empty: free run to the end of the store
            st.wr_span = size - wo_x;
            st.rd_span = '0;
        end
        else
        begin
            // full: held run to the end of the store
            st.wr_span = '0;
            st.rd_span = size - ro_x;
        end

        if (left == '0)
            st.level = LVL_FULL;
        else if (left <= (size >> 2))
            st.level = LVL_3Q;
        else if (left <= (size >> 1))
            st.level = LVL_HALF;
        else
            st.level = LVL_LOW;
    end

endmodule

// ----- hw/rtl/byte_ring_fifo_with_watermarks_unit.sv -----
// byte_ring_fifo_with_watermarks_unit: top level of the byte ring fifo
// depends on brfwm_pkg, brfwm_req_if, brfwm_rsp_if and brfwm_status
//
// usage
// - req channel: one transaction is a write of wr_byte, a read, or a clear of both
//   pointers (req_type); an unused code changes nothing and reports status
// - rsp channel: one result per request with the byte read, an accepted flag,
//   fill and free counts, contiguous spans and offsets, watermark level and event
// - apb port: register size_log2 at byte address 0, log2 of the capacity in use,
//   clamped to 3..10; any write to it also clears both pointers; write only when idle
// - a request passes the middle stage and the output register; the byte store is
//   a synchronous ram whose registered read data joins the status held there
// - throughput one transaction per cycle while the receiver keeps up, set by the
//   single pointer update and the one store access per request
// - a stalled receiver holds the output register; one more request is taken into
//   the middle stage, then ready drops until the output register drains
// - reset clears pointers, size_log2 (to 10) and the valid flags; the store has
//   no reset, and only bytes written since the last clear are ever read
module byte_ring_fifo_with_watermarks_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    brfwm_req_if.sink                    req,
    brfwm_rsp_if.source                  rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [brfwm_pkg::APB_AW-1:0] paddr,
    input  logic [brfwm_pkg::APB_DW-1:0] pwdata,
    output logic [brfwm_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import brfwm_pkg::*;

    // byte store, one write and one read port
    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [SIZE_W-1:0] size_log2_reg, size_log2_next;

    logic              s1_valid_reg, s1_valid_next;
    stage_t            s1_reg;
    stage_t            s1_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    stage_t            out_reg;

    logic [CNT_W-1:0]  size;
    logic [OFS_W-1:0]  mask;
    logic [CNT_W-1:0]  fill_pre;
    logic              fire;
    logic              s1_move;
    logic              cfg_wr;
    logic              wr_ok;
    logic              rd_ok;
    logic              acc;
    logic [PTR_W-1:0]  wp_step;
    logic [PTR_W-1:0]  rp_step;
    logic [OFS_W-1:0]  waddr;
    logic [OFS_W-1:0]  raddr;
    status_t           st_step;

    // apb: always ready, single register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_SIZE_LOG2);
    assign prdata = (paddr[APB_AW-1:2] == REG_SIZE_LOG2) ?
                    {{(APB_DW-SIZE_W){1'b0}}, size_log2_reg} : '0;

    // capacity in use
    assign size     = CNT_W'(1) << cap_log2(size_log2_reg);
    assign mask     = OFS_W'(size - CNT_W'(1));
    assign fill_pre = CNT_W'(wp_reg - rp_reg);
    assign waddr    = wp_reg[OFS_W-1:0] & mask;
    assign raddr    = rp_reg[OFS_W-1:0] & mask;

    // handshakes
    assign s1_move   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_move;
    assign fire      = req.valid && req.ready;

    // pointer step for the request on the channel
    always_comb
    begin
        wr_ok   = 1'b0;
        rd_ok   = 1'b0;
        acc     = 1'b0;
        wp_step = wp_reg;
        rp_step = rp_reg;
        case (req.req_type)
            REQ_WRITE:
            begin
                wr_ok = fill_pre < size;
                acc   = wr_ok;
                if (wr_ok)
                    wp_step = wp_reg + PTR_W'(1);
            end
            REQ_READ:
            begin
                rd_ok = fill_pre != '0;
                acc   = rd_ok;
                if (rd_ok)
                    rp_step = rp_reg + PTR_W'(1);
            end
            REQ_CLEAR:
            begin
                acc     = 1'b1;
                wp_step = '0;
                rp_step = '0;
            end
            default:
            begin
                // unused code: no change
                acc = 1'b0;
            end
        endcase
    end

    brfwm_status u_status (
        .wp   (wp_step),
        .rp   (rp_step),
        .size (size),
        .mask (mask),
        .st   (st_step)
    );

    always_comb
    begin
        s1_next                 = s1_reg;
        s1_next.rd_ok           = rd_ok;
        s1_next.accepted        = acc;
        s1_next.watermark_event = wr_ok && (st_step.level != LVL_LOW);
        s1_next.st              = st_step;
    end

    // control next state
    always_comb
    begin
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        size_log2_next = size_log2_reg;
        if (cfg_wr)
        begin
            size_log2_next = pwdata[SIZE_W-1:0];
            wp_next        = '0;
            rp_next        = '0;
        end
        else if (fire)
        begin
            wp_next = wp_step;
            rp_next = rp_step;
        end

        if (fire)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_move)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            size_log2_reg <= SIZE_LOG2_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            size_log2_reg <= size_log2_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // store: write at the accepting edge, read data registered
    always_ff @(posedge clk)
    begin
        if (fire && wr_ok)
            mem[waddr] <= req.wr_byte;
        if (fire && rd_ok)
            rdata_reg <= mem[raddr];
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (fire)
            s1_reg <= s1_next;
        if (s1_move)
        begin
            out_reg      <= s1_reg;
            out_byte_reg <= s1_reg.rd_ok ? rdata_reg : '0;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.rd_byte         = out_byte_reg;
    assign rsp.accepted        = out_reg.accepted;
    assign rsp.fill_count      = out_reg.st.fill_count;
    assign rsp.free_count      = out_reg.st.free_count;
    assign rsp.wr_offset       = out_reg.st.wr_offset;
    assign rsp.wr_span         = out_reg.st.wr_span;
    assign rsp.rd_offset       = out_reg.st.rd_offset;
    assign rsp.rd_span         = out_reg.st.rd_span;
    assign rsp.level           = out_reg.st.level;
    assign rsp.watermark_event = out_reg.watermark_event;

endmodule

// ----- hw/rtl/brfwm_checker.sv -----
// brfwm_checker: port-level assertions on the result channel, bound to the top level
// depends on brfwm_pkg and byte_ring_fifo_with_watermarks_unit
module brfwm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [brfwm_pkg::BYTE_W-1:0] rd_byte,
    input logic                         accepted,
    input logic [brfwm_pkg::CNT_W-1:0]  fill_count,
    input logic [brfwm_pkg::CNT_W-1:0]  free_count,
    input logic [brfwm_pkg::LVL_W-1:0]  level,
    input logic                         watermark_event
);
    import brfwm_pkg::*;

    logic [CNT_W:0] cap_sum;

    assign cap_sum = {1'b0, fill_count} + {1'b0, free_count};

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(fill_count) && $stable(rd_byte))
        else $error("stalled result changed");

    // fill plus free is a supported power-of-two capacity
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot(cap_sum) && (cap_sum >= (CNT_W + 1)'(1 << MIN_LOG2))
                      && (cap_sum <= (CNT_W + 1)'(DEPTH)))
        else $error("fill and free do not add to the capacity");

    // event only after an accepted write that leaves a watermark
    a_evt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && watermark_event |-> accepted && (level != LVL_LOW))
        else $error("watermark event without accepted write at a watermark");

    // full level exactly when nothing is free
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((level == LVL_FULL) == (free_count == '0)))
        else $error("full level and free count disagree");

    // refused requests return no byte
    a_byte: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !accepted |-> rd_byte == '0)
        else $error("byte returned for a refused request");

endmodule

bind byte_ring_fifo_with_watermarks_unit brfwm_checker u_brfwm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rd_byte         (rsp.rd_byte),
    .accepted        (rsp.accepted),
    .fill_count      (rsp.fill_count),
    .free_count      (rsp.free_count),
    .level           (rsp.level),
    .watermark_event (rsp.watermark_event)
);
